// ===== hdl/rswt_pkg.sv =====
// Shared types and fixed constants for the running statistics tracker.
// Depends on nothing; used by running_stats_worst_n_tracker_unit.
`default_nettype none

package rswt_pkg;

  localparam int unsigned WORD_W    = 32;  // count, sample and bucket count width
  localparam int unsigned SUM_W     = 64;  // wrapping sum and M2 width
  localparam int unsigned FIX_W     = 48;  // Q32.16 mean and EWMA width
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned EWMA_SHIFT = 4;  // alpha of 1/16
  localparam int unsigned M2_SHIFT  = 24;  // Q32.16 squared down to Q56.8
  localparam int unsigned STEP_W    = 6;   // iteration counter of divider and multiplier
  localparam int unsigned STAMP_W   = 64;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [SUM_W-1:0]  wide_t;
  typedef logic [FIX_W-1:0]  fix_t;

endpackage

`default_nettype wire

// ===== hdl/running_stats_worst_n_tracker_unit.sv =====
// Running statistics tracker: one sequencer driving an iterative divider,
// a shift-add multiplier, a bit-serial bucket scan and a slot scan.
// Each sample after the first passes through the 48-step mean divider and the 48-step
// M2 multiplier. One sample is in flight at a time, so a new sample is taken only once
// the last one's result is registered; a finished result may wait in the output register
// while the next sample is taken, and the sequencer holds at the end until it drains.
// Synchronous reset clears all statistics, histogram and worst-slot valid bits.
`default_nettype none

module running_stats_worst_n_tracker_unit #(
  parameter int unsigned WORST_SLOTS  = 8,
  parameter int unsigned BUCKET_COUNT = 32,
  parameter int unsigned SAMPLE_BITS  = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [31:0]               sample,
  input  wire logic [63:0]               stamp,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [31:0]                    total_count,
  output logic [63:0]                    running_sum,
  output logic [31:0]                    min_seen,
  output logic [31:0]                    max_seen,
  output logic [47:0]                    mean_fixed,
  output logic [63:0]                    spread_fixed,
  output logic [47:0]                    smooth_fixed,
  output logic [4:0]                     bucket_hit,
  output logic [31:0]                    bucket_total,
  output logic [2:0]                     worst_slot,
  output logic                           worst_taken
);

  localparam int unsigned SLOT_W = (WORST_SLOTS > 1) ? $clog2(WORST_SLOTS) : 1;
  localparam int unsigned HB_W   = $clog2(BUCKET_COUNT);
  localparam int unsigned FW     = rswt_pkg::FIX_W;
  localparam int unsigned WW     = rswt_pkg::WORD_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WORST_SLOTS - 1);
  localparam logic [5:0] HMAX = 6'(BUCKET_COUNT - 1);
  localparam logic [rswt_pkg::STEP_W-1:0] STEPS = rswt_pkg::STEP_W'(FW);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_DIV, S_MEAN, S_MULSET, S_MUL, S_SPREAD,
    S_BUCKET, S_HIST_RD, S_HIST_WR, S_WSCAN, S_WDEC
  } state_t;

  state_t state;

  // Statistics state
  rswt_pkg::word_t count_reg, min_reg, max_reg;
  rswt_pkg::wide_t sum_reg, spread_reg;
  rswt_pkg::fix_t  mean_reg, smooth_reg;

  // Current transaction
  rswt_pkg::word_t s_reg;
  logic [rswt_pkg::STAMP_W-1:0] stamp_reg;

  // Divider and multiplier
  logic              dneg;
  rswt_pkg::fix_t    dmag, quo, mcand;
  rswt_pkg::word_t   rem;
  logic [2*FW-1:0]   prod;
  logic [rswt_pkg::STEP_W-1:0] step;

  // Bucket scan
  rswt_pkg::word_t   bscan;
  logic [5:0]        bcount;
  logic [HB_W-1:0]   bk;
  rswt_pkg::word_t   bucket_cnt;

  // Memories and their valid bits
  rswt_pkg::word_t hist_mem [BUCKET_COUNT];
  rswt_pkg::word_t worst_mem [WORST_SLOTS];
  logic [rswt_pkg::STAMP_W-1:0] stamp_mem [WORST_SLOTS];
  logic [BUCKET_COUNT-1:0] hist_valid;
  logic [WORST_SLOTS-1:0]  worst_valid;
  rswt_pkg::word_t hist_q, wv_q;
  logic hvld_q, wvld_q;

  // Slot scan
  logic [SLOT_W-1:0] scan_idx, data_idx, best_idx;
  rswt_pkg::word_t   best_val;

  // Combinational datapath
  rswt_pkg::fix_t    x_fix, hist_dummy;
  logic [WW:0]       div_sh;
  logic              div_ge;
  logic [FW:0]       mul_sum;
  rswt_pkg::fix_t    mean_new, d2mag, ewma_mag, smooth_new;
  rswt_pkg::wide_t   term;
  logic [rswt_pkg::SUM_W:0] spread_sum;
  rswt_pkg::word_t   hist_old, hist_inc, wval;
  logic              take, out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign x_fix    = {s_reg, {rswt_pkg::FRAC_BITS{1'b0}}};
  assign hist_dummy = '0;

  always_comb begin
    div_sh   = {rem, quo[FW-1]};
    div_ge   = (div_sh >= {1'b0, count_reg});
    mul_sum  = {1'b0, prod[2*FW-1:FW]} + (prod[0] ? {1'b0, mcand} : {1'b0, hist_dummy});
    mean_new = dneg ? (mean_reg - quo) : (mean_reg + quo);
    d2mag    = (x_fix >= mean_reg) ? (x_fix - mean_reg) : (mean_reg - x_fix);
    // Truncation toward zero: shift the magnitude, then apply the sign.
    if (x_fix >= smooth_reg) begin
      ewma_mag   = (x_fix - smooth_reg) >> rswt_pkg::EWMA_SHIFT;
      smooth_new = smooth_reg + ewma_mag;
    end else begin
      ewma_mag   = (smooth_reg - x_fix) >> rswt_pkg::EWMA_SHIFT;
      smooth_new = smooth_reg - ewma_mag;
    end
    term = (|prod[2*FW-1:2*FW-8]) ? '1 : prod[2*FW-9:rswt_pkg::M2_SHIFT];
    spread_sum = {1'b0, spread_reg} + {1'b0, term};
    hist_old = hvld_q ? hist_q : '0;
    hist_inc = (hist_old == '1) ? hist_old : hist_old + 1'b1;
    wval     = wvld_q ? wv_q : '0;
    take     = (s_reg > best_val);
  end

  // Memory arrays, read every cycle with registered data.
  always_ff @(posedge clk) begin
    hist_q   <= hist_mem[bk];
    wv_q     <= worst_mem[scan_idx];
    if (state == S_HIST_WR) begin
      hist_mem[bk] <= hist_inc;
    end
    if (state == S_WDEC && out_free && take) begin
      worst_mem[best_idx] <= s_reg;
      stamp_mem[best_idx] <= stamp_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count_reg   <= '0;
      sum_reg     <= '0;
      min_reg     <= '0;
      max_reg     <= '0;
      mean_reg    <= '0;
      spread_reg  <= '0;
      smooth_reg  <= '0;
      hist_valid  <= '0;
      worst_valid <= '0;
      out_valid   <= 1'b0;
      hvld_q      <= 1'b0;
      wvld_q      <= 1'b0;
      bscan       <= '0;
    end else begin
      hvld_q   <= hist_valid[bk];
      wvld_q   <= worst_valid[scan_idx];
      data_idx <= scan_idx;
      // A result leaving in the same cycle as the next one is loaded is handled in S_WDEC.
      if (out_valid && !out_stall && state != S_WDEC) begin
        out_valid <= 1'b0;
      end
      if (bscan != '0) begin
        bscan  <= bscan >> 1;
        bcount <= bcount + 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            s_reg     <= WW'(sample[SAMPLE_BITS-1:0]);
            stamp_reg <= stamp;
            if (count_reg != '1) begin
              count_reg <= count_reg + 1'b1;
            end
            sum_reg <= sum_reg + rswt_pkg::SUM_W'(sample[SAMPLE_BITS-1:0]);
            state   <= S_SETUP;
          end
        end
        S_SETUP: begin
          bscan  <= s_reg;
          bcount <= '0;
          if (count_reg == WW'(1)) begin
            min_reg    <= s_reg;
            max_reg    <= s_reg;
            mean_reg   <= x_fix;
            smooth_reg <= x_fix;
            spread_reg <= '0;
            state      <= S_BUCKET;
          end else begin
            if (s_reg < min_reg) min_reg <= s_reg;
            if (s_reg > max_reg) max_reg <= s_reg;
            smooth_reg <= smooth_new;
            dneg <= (x_fix < mean_reg);
            dmag <= d2mag;
            quo  <= d2mag;
            rem  <= '0;
            step <= STEPS;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // One restoring division step per cycle: |d| / count.
          rem  <= div_ge ? WW'(div_sh - {1'b0, count_reg}) : div_sh[WW-1:0];
          quo  <= {quo[FW-2:0], div_ge};
          step <= step - 1'b1;
          if (step == 1) state <= S_MEAN;
        end
        S_MEAN: begin
          mean_reg <= mean_new;
          mcand    <= dmag;
          state    <= S_MULSET;
        end
        S_MULSET: begin
          prod  <= {{FW{1'b0}}, d2mag};
          step  <= STEPS;
          state <= S_MUL;
        end
        S_MUL: begin
          // Right-shifting shift-add multiplier, one multiplier bit per cycle.
          prod <= {mul_sum, prod[FW-1:1]};
          step <= step - 1'b1;
          if (step == 1) state <= S_SPREAD;
        end
        S_SPREAD: begin
          spread_reg <= spread_sum[rswt_pkg::SUM_W] ? '1 : spread_sum[rswt_pkg::SUM_W-1:0];
          state      <= S_BUCKET;
        end
        S_BUCKET: begin
          if (bscan == '0) begin
            bk    <= HB_W'((bcount > HMAX) ? HMAX : bcount);
            state <= S_HIST_RD;
          end
        end
        S_HIST_RD: begin
          scan_idx <= '0;
          state    <= S_HIST_WR;
        end
        S_HIST_WR: begin
          hist_valid[bk] <= 1'b1;
          bucket_cnt     <= hist_inc;
          best_val <= '1;
          best_idx <= '0;
          if (scan_idx != LAST_SLOT) scan_idx <= scan_idx + 1'b1;
          state <= S_WSCAN;
        end
        S_WSCAN: begin
          if (wval < best_val) begin
            best_val <= wval;
            best_idx <= data_idx;
          end
          if (scan_idx != LAST_SLOT) scan_idx <= scan_idx + 1'b1;
          if (data_idx == LAST_SLOT) state <= S_WDEC;
        end
        S_WDEC: begin
          if (out_free) begin
            if (take) worst_valid[best_idx] <= 1'b1;
            out_valid    <= 1'b1;
            total_count  <= count_reg;
            running_sum  <= sum_reg;
            min_seen     <= min_reg;
            max_seen     <= max_reg;
            mean_fixed   <= mean_reg;
            spread_fixed <= spread_reg;
            smooth_fixed <= smooth_reg;
            bucket_hit   <= 5'(bk);
            bucket_total <= bucket_cnt;
            worst_slot   <= 3'(best_idx);
            worst_taken  <= take;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== verif/running_stats_worst_n_tracker_unit_checker.sv =====
// Checker for the running statistics tracker: predicts each result from the
// accepted sample transactions and compares it field by field. Uses rswt_pkg.
`default_nettype none

module running_stats_worst_n_tracker_unit_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [31:0] sample,
  input  wire logic [63:0] stamp,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [31:0] total_count,
  input  wire logic [63:0] running_sum,
  input  wire logic [31:0] min_seen,
  input  wire logic [31:0] max_seen,
  input  wire logic [47:0] mean_fixed,
  input  wire logic [63:0] spread_fixed,
  input  wire logic [47:0] smooth_fixed,
  input  wire logic [4:0]  bucket_hit,
  input  wire logic [31:0] bucket_total,
  input  wire logic [2:0]  worst_slot,
  input  wire logic        worst_taken,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 8;
  localparam int NBUCK = 32;

  typedef struct packed {
    rswt_pkg::word_t cnt;
    rswt_pkg::wide_t sum;
    rswt_pkg::word_t mn;
    rswt_pkg::word_t mx;
    rswt_pkg::fix_t  mean;
    rswt_pkg::wide_t m2;
    rswt_pkg::fix_t  ewma;
    logic [4:0]      bk;
    rswt_pkg::word_t bkcnt;
    logic [2:0]      slot;
    logic            taken;
  } stats_t;

  stats_t stats_q[$];

  rswt_pkg::word_t cnt_s, mn_s, mx_s;
  rswt_pkg::wide_t sum_s, m2_s;
  rswt_pkg::fix_t  mean_s, ewma_s;
  rswt_pkg::word_t hist_s [NBUCK];
  rswt_pkg::word_t worst_s [NSLOT];

  // Absolute product shifted down to Q56.8, saturating when it overflows 64 bits.
  function automatic rswt_pkg::wide_t m2_term(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = (128'(a) * 128'(b)) >> rswt_pkg::M2_SHIFT;
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  function automatic stats_t update_stats(rswt_pkg::word_t s);
    stats_t r;
    logic signed [63:0] x, d, d2, e, q;
    rswt_pkg::wide_t t;
    int unsigned b, sl;
    x = 64'(s) << rswt_pkg::FRAC_BITS;
    if (cnt_s != '1) cnt_s++;
    sum_s += 64'(s);
    if (cnt_s == 1) begin
      mn_s = s; mx_s = s; mean_s = x[47:0]; m2_s = '0; ewma_s = x[47:0];
    end else begin
      if (s < mn_s) mn_s = s;
      if (s > mx_s) mx_s = s;
      d = x - $signed({16'd0, mean_s});
      q = d / $signed({32'd0, cnt_s});
      mean_s = 48'($signed({16'd0, mean_s}) + q);
      d2 = x - $signed({16'd0, mean_s});
      t = m2_term(d < 0 ? -d : d, d2 < 0 ? -d2 : d2);
      m2_s = (m2_s > ~t) ? '1 : m2_s + t;
      e = x - $signed({16'd0, ewma_s});
      ewma_s = 48'($signed({16'd0, ewma_s}) + e / 16);
    end
    b = 0;
    for (int i = 0; i < 32; i++) if (s[i]) b = i + 1;
    if (b > NBUCK - 1) b = NBUCK - 1;
    if (hist_s[b] != '1) hist_s[b]++;
    sl = 0;
    for (int i = 1; i < NSLOT; i++) if (worst_s[i] < worst_s[sl]) sl = i;
    r.taken = s > worst_s[sl];
    if (r.taken) worst_s[sl] = s;
    r.cnt = cnt_s; r.sum = sum_s; r.mn = mn_s; r.mx = mx_s; r.mean = mean_s;
    r.m2 = m2_s; r.ewma = ewma_s; r.bk = b[4:0]; r.bkcnt = hist_s[b];
    r.slot = sl[2:0];
    return r;
  endfunction

  task automatic compare(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $realtime, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    stats_t w;
    if (rst) begin
      cnt_s = '0; sum_s = '0; mn_s = '0; mx_s = '0; mean_s = '0; m2_s = '0; ewma_s = '0;
      foreach (hist_s[i]) hist_s[i] = '0;
      foreach (worst_s[i]) worst_s[i] = '0;
      stats_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (stats_q.size() == 0) begin
          $display("%0t: result transaction with none expected, count %0h", $realtime,
                   total_count);
          fail_count++;
        end else begin
          w = stats_q.pop_front();
          compare("total_count", 64'(w.cnt), 64'(total_count));
          compare("running_sum", w.sum, running_sum);
          compare("min_seen", 64'(w.mn), 64'(min_seen));
          compare("max_seen", 64'(w.mx), 64'(max_seen));
          compare("mean_fixed", 64'(w.mean), 64'(mean_fixed));
          compare("spread_fixed", w.m2, spread_fixed);
          compare("smooth_fixed", 64'(w.ewma), 64'(smooth_fixed));
          compare("bucket_hit", 64'(w.bk), 64'(bucket_hit));
          compare("bucket_total", 64'(w.bkcnt), 64'(bucket_total));
          compare("worst_slot", 64'(w.slot), 64'(worst_slot));
          compare("worst_taken", 64'(w.taken), 64'(worst_taken));
        end
      end
      if (in_valid && !in_stall) stats_q.push_back(update_stats(sample));
    end
    pending = stats_q.size();
  end

endmodule

`default_nettype wire

// ===== verif/running_stats_worst_n_tracker_unit_tb.sv =====
// Testbench top for the running statistics tracker: clock, reset, sample
// stimulus with random idling and stalls, and the verdict. Uses the checker module.
`default_nettype none

module running_stats_worst_n_tracker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic [31:0] sample = 0;
  logic [63:0] stamp = 0;
  logic in_stall, out_valid, worst_taken;
  logic [31:0] total_count, min_seen, max_seen, bucket_total;
  logic [63:0] running_sum, spread_fixed;
  logic [47:0] mean_fixed, smooth_fixed;
  logic [4:0] bucket_hit;
  logic [2:0] worst_slot;
  int fail_count, pending;
  int idle_cycles = 0;
  bit calm = 0, hold_off = 0;

  always #10 clk = ~clk;

  running_stats_worst_n_tracker_unit uut (.*);
  running_stats_worst_n_tracker_unit_checker chk (.*);

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst || hold_off) out_stall <= 1'b1;
    else out_stall <= !calm && ($urandom_range(99) < 9);
  end

  task automatic send_sample(logic [31:0] s, logic [63:0] t);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    stamp <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(5))
      0: return $urandom_range(15);
      1: return 32'hFFFF_FFFF - $urandom_range(15);
      2: return $urandom >> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Directed: zero first, extremes, equal values, decreasing and rising runs.
    send_sample(32'd0, 64'd0);
    send_sample(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sample(32'hFFFF_FFFF, 64'h5555_5555_5555_5555);
    send_sample(32'd1, 64'hAAAA_AAAA_AAAA_AAAA);
    send_sample(32'd0, 64'd1);
    for (int i = 0; i < 10; i++) send_sample(32'd1 << (3 * i), {$urandom, $urandom});
    send_sample(32'h8000_0000, 64'd7);
    send_sample(32'h7FFF_FFFF, 64'd8);
    send_sample(32'd2, 64'd9);
    // Long receiver hold-off while samples keep coming, so the input stalls.
    hold_off = 1;
    fork
      begin repeat (600) @(negedge clk); hold_off = 0; end
      for (int i = 0; i < 6; i++) send_sample(rand_sample(), {$urandom, $urandom});
    join
    in_valid <= 1'b0;
    wait (pending == 0);
    for (int i = 0; i < 900; i++) begin
      calm = (i >= 300 && i < 400);
      send_sample(rand_sample(), {$urandom, $urandom});
      if (i == 500) begin
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
    end
    calm = 0;
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
